FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mct_pkg.sv
// Types, constants and helper functions of the MACD crossover trader.
package mct_pkg;

    // Default periods and counter width.
    localparam int FAST_PERIOD_DEF   = 12;
    localparam int SLOW_PERIOD_DEF   = 26;
    localparam int SIGNAL_PERIOD_DEF = 9;
    localparam int COUNT_WIDTH_DEF   = 24;

    // Series milestones.
    localparam int MIN_SAMPLES = 35;
    localparam int TRADE_START = 34;
    localparam int MACD_START  = 25;

    // Datapath widths.
    localparam int PRICE_W = 32;
    localparam int ACC_W   = 50;
    localparam int DIV_W   = 56;
    localparam int DVS_W   = 32;
    localparam int TOTAL_W = 48;
    localparam int TC_W    = 24;
    localparam int SUCC_W  = 23;
    localparam int OUT_W   = 120;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_ENTER_LONG  = 3'd1,
        ACT_EXIT_LONG   = 3'd2,
        ACT_ENTER_SHORT = 3'd3,
        ACT_EXIT_SHORT  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        REL_EQUAL   = 2'd0,
        REL_LESS    = 2'd1,
        REL_GREATER = 2'd2
    } rel_t;

    typedef enum logic [1:0] {
        POS_NONE  = 2'd0,
        POS_LONG  = 2'd1,
        POS_SHORT = 2'd2
    } pos_t;

    typedef enum logic [1:0] {
        EMA_FAST   = 2'd0,
        EMA_SLOW   = 2'd1,
        EMA_SIGNAL = 2'd2
    } ema_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMA_PREP,
        ST_EMA_WAIT,
        ST_TRADE,
        ST_RET_WAIT,
        ST_CLOSE,
        ST_SUM,
        ST_SUCC_WAIT,
        ST_AVG_WAIT,
        ST_FINISH
    } state_t;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Saturate a sign and magnitude pair to a signed 32-bit value.
    function automatic logic signed [31:0] sat32(input logic neg, input logic [DIV_W-1:0] mag);
        logic signed [31:0] res;
        if (!neg) begin
            res = (mag > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
        end
        else begin
            res = (mag > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(mag[31:0]);
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/mct_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"

module mct_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  mct_pkg::div_req_t req,
    output mct_pkg::div_rsp_t rsp
);

    localparam int DW = mct_pkg::DIV_W;
    localparam int VW = mct_pkg::DVS_W;
    localparam int CNT_W = $clog2(DW);

    logic [VW:0]      rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [VW:0]      trial;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        trial    = {rem_reg[VW-1:0], quo_reg[DW-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? (trial - {1'b0, dvs_reg}) : trial;
        quo_next = {quo_reg[DW-2:0], fits};
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_reg, "divider did not start")
    `ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, !busy_reg, "divider done while busy")

endmodule

FILE: hw/rtl/macd_crossover_trader_core.sv
// MACD crossover trader: sequencer, series state and result register.
// Each beat passes through EMA prep for the fast, slow and signal EMAs, the trade decision,
// the sum step and the finish state; each EMA seed end or update, the return of a trade
// closed at a nonzero entry and each of the two summary figures waits on the shared divider,
// a close adds the close state. s_tready is high only while the sequencer idles.
// Reset clears the series state, the threshold and the result register at once.
`include "assert_macros.svh"

module macd_crossover_trader_core #(
    parameter int FAST_PERIOD   = mct_pkg::FAST_PERIOD_DEF,
    parameter int SLOW_PERIOD   = mct_pkg::SLOW_PERIOD_DEF,
    parameter int SIGNAL_PERIOD = mct_pkg::SIGNAL_PERIOD_DEF,
    parameter int COUNT_WIDTH   = mct_pkg::COUNT_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // close_price
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    // action[2:0], trade_closed[3], trade_return[35:4], trade_profitable[36],
    // summary_valid[37], too_few_samples[38], trade_count[62:39],
    // success_pct[85:63], avg_return_pct[117:86], zero fill[119:118]
    output logic [119:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data
);

    localparam int MAX_FS    = (FAST_PERIOD > SLOW_PERIOD) ? FAST_PERIOD : SLOW_PERIOD;
    localparam int MAX_FSS   = (MAX_FS > SIGNAL_PERIOD) ? MAX_FS : SIGNAL_PERIOD;
    localparam int IDX_LIMIT = (MAX_FSS > mct_pkg::MIN_SAMPLES) ? MAX_FSS : mct_pkg::MIN_SAMPLES;
    localparam int IDX_W     = $clog2(IDX_LIMIT + 1);
    localparam int PW        = IDX_W + 1;
    localparam int AW        = mct_pkg::ACC_W;
    localparam int DW        = mct_pkg::DIV_W;
    localparam int VW        = mct_pkg::DVS_W;
    localparam int TW        = mct_pkg::TOTAL_W;
    localparam int CW        = COUNT_WIDTH;
    localparam int NW        = AW + PW + 1;

    mct_pkg::state_t   state_reg, state_next;
    mct_pkg::ema_sel_t sel_reg;
    mct_pkg::rel_t     rel_reg;
    mct_pkg::pos_t     pos_reg;
    mct_pkg::action_t  action_reg;

    logic [IDX_W-1:0]     idx_reg;
    logic signed [AW-1:0] fast_acc_reg, slow_acc_reg, sig_acc_reg;
    logic signed [AW-1:0] fval_reg, sval_reg, sigval_reg, m_reg;
    logic                 neg_reg;
    logic [31:0]          entry_reg, price_reg;
    logic                 last_reg;
    logic signed [TW-1:0] total_reg;
    logic [CW-1:0]        closed_reg, win_reg;
    logic signed [31:0]   thr_reg, ret_reg, avg_reg;
    logic                 closed_flag_reg, prof_reg;
    logic [22:0]          succ_reg;
    logic                 out_valid_reg;
    logic [119:0]         out_data_reg;

    mct_pkg::div_req_t div_req;
    mct_pkg::div_rsp_t div_rsp;

    // EMA step datapath.
    logic signed [AW-1:0] acc_cur, x_ext, m_new, xk, sum_k, q_acc;
    logic [PW-1:0]        n_cur, nm1, i1;
    logic                 seeding, seedend;
    logic signed [NW-1:0] prod, upd;
    logic signed [DW:0]   num;
    logic [DW-1:0]        num_mag;

    // Trade decision datapath.
    mct_pkg::rel_t    rel;
    mct_pkg::pos_t    pos1, close_pos;
    mct_pkg::action_t act;
    logic             up, down, opened, close_now;
    logic [31:0]      close_entry;
    logic signed [32:0] diff;
    logic [32:0]      diff_mag;
    logic signed [31:0] ret_zero_entry;

    // Bookkeeping datapath.
    logic signed [TW:0]   tsum;
    logic signed [TW-1:0] total_new;
    logic                 win_new;
    logic                 few;
    logic [TW-1:0]        total_mag;
    logic                 sum_go;
    logic [mct_pkg::TC_W-1:0] trade_cnt;

    mct_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // EMA operand selection and numerator.
    always_comb
    begin
        case (sel_reg)
            mct_pkg::EMA_FAST:   begin acc_cur = fast_acc_reg; n_cur = PW'(FAST_PERIOD);   end
            mct_pkg::EMA_SLOW:   begin acc_cur = slow_acc_reg; n_cur = PW'(SLOW_PERIOD);   end
            default:             begin acc_cur = sig_acc_reg;  n_cur = PW'(SIGNAL_PERIOD); end
        endcase
        x_ext   = $signed({{(AW - 40){1'b0}}, price_reg, 8'h00});
        m_new   = (idx_reg >= IDX_W'(mct_pkg::MACD_START)) ? (fval_reg - sval_reg) : '0;
        xk      = (sel_reg == mct_pkg::EMA_SIGNAL) ? m_new : x_ext;
        i1      = {1'b0, idx_reg} + PW'(1);
        seeding = i1 < n_cur;
        seedend = i1 == n_cur;
        sum_k   = acc_cur + xk;
        nm1     = n_cur - PW'(1);
        prod    = NW'(acc_cur) * $signed({1'b0, nm1});
        upd     = prod + (NW'(xk) <<< 1);
        num     = seedend ? (DW + 1)'(sum_k) : (DW + 1)'(upd);
        num_mag = num[DW] ? DW'(-num) : DW'(num);
        q_acc   = neg_reg ? -$signed(AW'(div_rsp.quotient)) : $signed(AW'(div_rsp.quotient));
    end

    // Crossover decision and the trade to close, if any.
    always_comb
    begin
        rel = (m_reg < sigval_reg) ? mct_pkg::REL_LESS :
              ((m_reg > sigval_reg) ? mct_pkg::REL_GREATER : mct_pkg::REL_EQUAL);
        up        = (rel_reg == mct_pkg::REL_LESS) && (rel == mct_pkg::REL_GREATER);
        down      = (rel_reg == mct_pkg::REL_GREATER) && (rel == mct_pkg::REL_LESS);
        pos1      = pos_reg;
        act       = mct_pkg::ACT_NONE;
        opened    = 1'b0;
        close_now = 1'b0;
        close_pos = pos_reg;
        if (idx_reg >= IDX_W'(mct_pkg::TRADE_START))
        begin
            case (pos_reg)
                mct_pkg::POS_NONE:
                begin
                    if (up)
                    begin
                        pos1 = mct_pkg::POS_LONG; opened = 1'b1; act = mct_pkg::ACT_ENTER_LONG;
                    end
                    else if (down)
                    begin
                        pos1 = mct_pkg::POS_SHORT; opened = 1'b1;
                        act  = mct_pkg::ACT_ENTER_SHORT;
                    end
                end
                mct_pkg::POS_LONG:
                begin
                    if (down)
                    begin
                        close_now = 1'b1; act = mct_pkg::ACT_EXIT_LONG;
                    end
                end
                default:
                begin
                    if (up)
                    begin
                        close_now = 1'b1; act = mct_pkg::ACT_EXIT_SHORT;
                    end
                end
            endcase
        end
        // The last beat closes whatever is still open at its own price.
        if (last_reg && !close_now && (pos1 != mct_pkg::POS_NONE))
        begin
            close_now = 1'b1;
            close_pos = pos1;
            act = (pos1 == mct_pkg::POS_LONG) ? mct_pkg::ACT_EXIT_LONG : mct_pkg::ACT_EXIT_SHORT;
        end
        close_entry = opened ? price_reg : entry_reg;
        diff = (close_pos == mct_pkg::POS_LONG) ?
               ($signed({1'b0, price_reg}) - $signed({1'b0, close_entry})) :
               ($signed({1'b0, close_entry}) - $signed({1'b0, price_reg}));
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
        ret_zero_entry = diff[32] ? 32'sh8000_0000 :
                         ((diff != 33'sd0) ? 32'sh7FFF_FFFF : 32'sd0);
    end

    // Trade bookkeeping and summary conditions.
    always_comb
    begin
        tsum      = (TW + 1)'(total_reg) + (TW + 1)'(ret_reg);
        if (tsum > $signed({2'b00, {(TW - 1){1'b1}}}))
            total_new = {1'b0, {(TW - 1){1'b1}}};
        else if (tsum < $signed({2'b11, {(TW - 1){1'b0}}}))
            total_new = {1'b1, {(TW - 1){1'b0}}};
        else
            total_new = TW'(tsum);
        win_new   = ret_reg > thr_reg;
        few       = last_reg && ({1'b0, idx_reg} + PW'(1) < PW'(mct_pkg::MIN_SAMPLES));
        sum_go    = last_reg && !few && (closed_reg != '0);
        total_mag = total_reg[TW-1] ? TW'(-total_reg) : TW'(total_reg);
        trade_cnt = (closed_reg > CW'(mct_pkg::TC_W'('1))) ? '1 : mct_pkg::TC_W'(closed_reg);
    end

    // Sequencer next state and divider requests.
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = num_mag;
        div_req.divisor  = seedend ? VW'(n_cur) : VW'(n_cur + PW'(1));
        case (state_reg)
            mct_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = mct_pkg::ST_EMA_PREP;
            end
            mct_pkg::ST_EMA_PREP:
            begin
                if (seeding)
                    state_next = (sel_reg == mct_pkg::EMA_SIGNAL) ? mct_pkg::ST_TRADE
                                                                  : mct_pkg::ST_EMA_PREP;
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = mct_pkg::ST_EMA_WAIT;
                end
            end
            mct_pkg::ST_EMA_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (sel_reg == mct_pkg::EMA_SIGNAL) ? mct_pkg::ST_TRADE
                                                                  : mct_pkg::ST_EMA_PREP;
            end
            mct_pkg::ST_TRADE:
            begin
                div_req.dividend = DW'({diff_mag[31:0], 16'h0000});
                div_req.divisor  = VW'(close_entry);
                if (!close_now)
                    state_next = mct_pkg::ST_SUM;
                else if (close_entry == 32'd0)
                    state_next = mct_pkg::ST_CLOSE;
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = mct_pkg::ST_RET_WAIT;
                end
            end
            mct_pkg::ST_RET_WAIT:
            begin
                if (div_rsp.done)
                    state_next = mct_pkg::ST_CLOSE;
            end
            mct_pkg::ST_CLOSE:
            begin
                state_next = mct_pkg::ST_SUM;
            end
            mct_pkg::ST_SUM:
            begin
                div_req.dividend = DW'(DW'(win_reg) * DW'(100)) << 16;
                div_req.divisor  = VW'(closed_reg);
                if (sum_go)
                begin
                    div_req.start = 1'b1;
                    state_next    = mct_pkg::ST_SUCC_WAIT;
                end
                else
                    state_next = mct_pkg::ST_FINISH;
            end
            mct_pkg::ST_SUCC_WAIT:
            begin
                div_req.dividend = DW'(total_mag) * DW'(100);
                div_req.divisor  = VW'(closed_reg);
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    state_next    = mct_pkg::ST_AVG_WAIT;
                end
            end
            mct_pkg::ST_AVG_WAIT:
            begin
                if (div_rsp.done)
                    state_next = mct_pkg::ST_FINISH;
            end
            mct_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = mct_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mct_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mct_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_wr_en)
            thr_reg <= $signed(cfg_wr_data);
    end

    // Series state and per-beat working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            fast_acc_reg    <= '0;
            slow_acc_reg    <= '0;
            sig_acc_reg     <= '0;
            rel_reg         <= mct_pkg::REL_EQUAL;
            pos_reg         <= mct_pkg::POS_NONE;
            entry_reg       <= '0;
            total_reg       <= '0;
            closed_reg      <= '0;
            win_reg         <= '0;
            sel_reg         <= mct_pkg::EMA_FAST;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            action_reg      <= mct_pkg::ACT_NONE;
            price_reg       <= '0;
            last_reg        <= 1'b0;
            closed_flag_reg <= 1'b0;
            ret_reg         <= '0;
            prof_reg        <= 1'b0;
            succ_reg        <= '0;
            avg_reg         <= '0;
            neg_reg         <= 1'b0;
            m_reg           <= '0;
            fval_reg        <= '0;
            sval_reg        <= '0;
            sigval_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready && (state_reg != mct_pkg::ST_FINISH))
                out_valid_reg <= 1'b0;
            case (state_reg)
                mct_pkg::ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        price_reg       <= s_tdata;
                        last_reg        <= s_tlast;
                        sel_reg         <= mct_pkg::EMA_FAST;
                        closed_flag_reg <= 1'b0;
                        ret_reg         <= '0;
                        prof_reg        <= 1'b0;
                        succ_reg        <= '0;
                        avg_reg         <= '0;
                    end
                end
                mct_pkg::ST_EMA_PREP:
                begin
                    neg_reg <= num[DW];
                    if (sel_reg == mct_pkg::EMA_SIGNAL)
                        m_reg <= m_new;
                    if (seeding)
                    begin
                        case (sel_reg)
                            mct_pkg::EMA_FAST: begin fast_acc_reg <= sum_k; fval_reg <= '0; end
                            mct_pkg::EMA_SLOW: begin slow_acc_reg <= sum_k; sval_reg <= '0; end
                            default:           begin sig_acc_reg <= sum_k; sigval_reg <= '0; end
                        endcase
                        if (sel_reg == mct_pkg::EMA_FAST)
                            sel_reg <= mct_pkg::EMA_SLOW;
                        else if (sel_reg == mct_pkg::EMA_SLOW)
                            sel_reg <= mct_pkg::EMA_SIGNAL;
                    end
                end
                mct_pkg::ST_EMA_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        case (sel_reg)
                            mct_pkg::EMA_FAST: begin fast_acc_reg <= q_acc; fval_reg <= q_acc; end
                            mct_pkg::EMA_SLOW: begin slow_acc_reg <= q_acc; sval_reg <= q_acc; end
                            default:           begin sig_acc_reg <= q_acc; sigval_reg <= q_acc; end
                        endcase
                        if (sel_reg == mct_pkg::EMA_FAST)
                            sel_reg <= mct_pkg::EMA_SLOW;
                        else if (sel_reg == mct_pkg::EMA_SLOW)
                            sel_reg <= mct_pkg::EMA_SIGNAL;
                    end
                end
                mct_pkg::ST_TRADE:
                begin
                    rel_reg         <= rel;
                    pos_reg         <= close_now ? mct_pkg::POS_NONE : pos1;
                    entry_reg       <= close_entry;
                    action_reg      <= act;
                    closed_flag_reg <= close_now;
                    neg_reg         <= diff[32];
                    ret_reg         <= close_now ? ret_zero_entry : 32'sd0;
                end
                mct_pkg::ST_RET_WAIT:
                begin
                    if (div_rsp.done)
                        ret_reg <= mct_pkg::sat32(neg_reg, div_rsp.quotient);
                end
                mct_pkg::ST_CLOSE:
                begin
                    total_reg <= total_new;
                    prof_reg  <= win_new;
                    if (closed_reg != '1)
                        closed_reg <= closed_reg + CW'(1);
                    if (win_new && (win_reg != '1))
                        win_reg <= win_reg + CW'(1);
                end
                mct_pkg::ST_SUCC_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        succ_reg <= div_rsp.quotient[22:0];
                        neg_reg  <= total_reg[TW-1];
                    end
                end
                mct_pkg::ST_AVG_WAIT:
                begin
                    if (div_rsp.done)
                        avg_reg <= mct_pkg::sat32(neg_reg, div_rsp.quotient);
                end
                mct_pkg::ST_FINISH:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {2'b00,
                                          (last_reg && sum_go) ? avg_reg : 32'sd0,
                                          (last_reg && sum_go) ? succ_reg : 23'd0,
                                          (last_reg && sum_go) ? trade_cnt : 24'd0,
                                          few, last_reg, prof_reg, ret_reg,
                                          closed_flag_reg, action_reg};
                        if (last_reg)
                        begin
                            idx_reg      <= '0;
                            fast_acc_reg <= '0;
                            slow_acc_reg <= '0;
                            sig_acc_reg  <= '0;
                            rel_reg      <= mct_pkg::REL_EQUAL;
                            pos_reg      <= mct_pkg::POS_NONE;
                            entry_reg    <= '0;
                            total_reg    <= '0;
                            closed_reg   <= '0;
                            win_reg      <= '0;
                        end
                        else if (idx_reg < IDX_W'(IDX_LIMIT))
                            idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = (state_reg == mct_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_ALWAYS(a_win_le_closed, clk, rst_n, win_reg <= closed_reg, "more wins than trades")
    `ASSERT_ALWAYS(a_idx_limit, clk, rst_n, idx_reg <= IDX_W'(IDX_LIMIT), "sample index overran")
    `ASSERT_IMPL(a_div_expected, clk, rst_n, div_rsp.done, state_reg == mct_pkg::ST_EMA_WAIT || state_reg == mct_pkg::ST_RET_WAIT || state_reg == mct_pkg::ST_SUCC_WAIT || state_reg == mct_pkg::ST_AVG_WAIT, "divider result not awaited")

endmodule
